// File: src/vrt_pkg.sv
// vrt_pkg: shared types and constants for the velocity rescale thermostat
// request/response payloads, register indexes, controller command and status
// no dependencies
`timescale 1ns / 1ps

package vrt_pkg;

   localparam int COUNT_BITS = 20;
   localparam int DIV_STEPS  = 65;
   localparam int SQRT_STEPS = 28;
   localparam int STEP_BITS  = $clog2(DIV_STEPS + 1);

   localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
   localparam logic [23:0] TARGET_RST  = 24'h01_0000;

   localparam logic [1:0] CSR_TARGET_TEMP    = 2'd0;
   localparam logic [1:0] CSR_PARTICLE_COUNT = 2'd1;
   localparam logic [1:0] CSR_GROUP_MODE     = 2'd2;

   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_SCALE      = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [19:0] particle_index;
      logic [31:0] vel_x;
      logic [31:0] vel_y;
      logic [15:0] mass;
   } req_type;

   typedef struct packed {
      logic [19:0] out_index;
      logic [31:0] scaled_vel_x;
      logic [31:0] scaled_vel_y;
      logic [47:0] vel_sq;
      logic        factor_error;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic square;
      logic sum;
      logic mul;
      logic resp_load;
      logic div1_load;
      logic div_step;
      logic div2_load;
      logic sqrt_load;
      logic sqrt_step;
      logic sqrt_last;
   } cmd_type;

   typedef struct packed {
      logic is_scale;
      logic factor_ready;
      logic temp_zero;
      logic rsp_free;
   } status_type;

endpackage

// File: src/vrt_ctrl.sv
// vrt_ctrl: sequencer for accumulate, factor computation and scale requests
// depends on vrt_pkg
`timescale 1ns / 1ps

module vrt_ctrl import vrt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_SQ    = 11'b000_0000_0010,
      ST_SUM   = 11'b000_0000_0100,
      ST_MUL   = 11'b000_0000_1000,
      ST_RESP  = 11'b000_0001_0000,
      ST_PREP1 = 11'b000_0010_0000,
      ST_DIV1  = 11'b000_0100_0000,
      ST_PREP2 = 11'b000_1000_0000,
      ST_DIV2  = 11'b001_0000_0000,
      ST_PREP3 = 11'b010_0000_0000,
      ST_SQRT  = 11'b100_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 last_step;

   assign last_step = (step_ff == STEP_BITS'(1));
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.square = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            if (status.is_scale && !status.factor_ready) state_in = ST_PREP1;
            else state_in = ST_MUL;
         end
         ST_PREP1: begin
            cmd.div1_load = 1'b1;
            step_in       = STEP_BITS'(DIV_STEPS);
            state_in      = ST_DIV1;
         end
         ST_DIV1: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - STEP_BITS'(1);
            if (last_step) state_in = ST_PREP2;
         end
         ST_PREP2: begin
            // zero temperature settles the factor right here
            cmd.div2_load = 1'b1;
            step_in       = STEP_BITS'(DIV_STEPS);
            if (status.temp_zero) state_in = ST_MUL;
            else state_in = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - STEP_BITS'(1);
            if (last_step) state_in = ST_PREP3;
         end
         ST_PREP3: begin
            cmd.sqrt_load = 1'b1;
            step_in       = STEP_BITS'(SQRT_STEPS);
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cmd.sqrt_last = last_step;
            step_in       = step_ff - STEP_BITS'(1);
            if (last_step) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.resp_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_step_live: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step || cmd.sqrt_step) |-> (step_ff != '0))
      else $error("iteration step without count");
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_ready)
      else $error("request taken while busy");
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |=> req_ready)
      else $error("response load did not return to idle");

endmodule

// File: src/vrt_datapath.sv
// vrt_datapath: squares, energy sum, shared shift-subtract divider, root unit,
// velocity scaling, configuration registers and response register
// depends on vrt_pkg
`timescale 1ns / 1ps

module vrt_datapath import vrt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_payload,
   input  logic        csr_valid,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  cmd_type     cmd,
   output status_type  status
);

   logic [23:0]           target_ff, target_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  group_ff, group_in;

   logic [63:0] energy_ff, energy_in;
   logic [31:0] factor_ff, factor_in;
   logic        ready_ff, ready_in;
   logic        zflag_ff, zflag_in;

   req_type     item_ff, item_in;
   logic [63:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [47:0] vv_ff, vv_in;
   logic [54:0] term_ff, term_in;
   logic signed [64:0] px_ff, px_in, py_ff, py_in;

   logic [64:0] num_ff, num_in, quo_ff, quo_in;
   logic [63:0] den_ff, den_in, rem_ff, rem_in;
   logic [55:0] sn_ff, sn_in, res_ff, res_in, bit_ff, bit_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [31:0]           ax, ay;
   logic [COUNT_BITS-1:0] cnt_eff;
   logic [64:0]           trial, energy_sum;
   logic [56:0]           sq_trial;
   logic [63:0]           energy_base;
   logic [31:0]           sx, sy;

   function automatic logic [31:0] sat_shift(input logic signed [64:0] p);
      logic signed [64:0] q;
      q = p >>> 16;
      if (q > 65'sh0_7FFF_FFFF) sat_shift = 32'h7FFF_FFFF;
      else if (q < -65'sh0_8000_0000) sat_shift = 32'h8000_0000;
      else sat_shift = q[31:0];
   endfunction

   assign ax       = item_ff.vel_x[31] ? 32'(-item_ff.vel_x) : item_ff.vel_x;
   assign ay       = item_ff.vel_y[31] ? 32'(-item_ff.vel_y) : item_ff.vel_y;
   assign cnt_eff  = (count_ff == '0) ? COUNT_BITS'(1) : count_ff;
   assign trial    = {rem_ff, num_ff[64]};
   assign sq_trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign energy_base = ready_ff ? 64'd0 : energy_ff;
   assign energy_sum  = {1'b0, energy_base} + {10'd0, term_ff};
   assign sx = sat_shift(px_ff);
   assign sy = sat_shift(py_ff);

   assign status.is_scale     = (item_ff.opcode == OP_SCALE);
   assign status.factor_ready = ready_ff;
   assign status.temp_zero    = (quo_ff[63:0] == 64'd0);
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      target_in = target_ff;
      count_in  = count_ff;
      group_in  = group_ff;
      energy_in = energy_ff;
      factor_in = factor_ff;
      ready_in  = ready_ff;
      zflag_in  = zflag_ff;
      item_in   = item_ff;
      sqx_in    = sqx_ff;
      sqy_in    = sqy_ff;
      vv_in     = vv_ff;
      term_in   = term_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      sn_in     = sn_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      rsp_in    = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         case (csr_index)
            CSR_TARGET_TEMP:    target_in = csr_wdata[23:0];
            CSR_PARTICLE_COUNT: count_in  = csr_wdata[COUNT_BITS-1:0];
            CSR_GROUP_MODE:     group_in  = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.capture) item_in = req_payload;
      if (cmd.square) begin
         sqx_in = ax * ax;
         sqy_in = ay * ay;
      end
      if (cmd.sum) vv_in = 48'((sqx_ff + sqy_ff) >> 16);

      if (cmd.div1_load) begin
         num_in = group_ff ? {energy_ff, 1'b0} : {1'b0, energy_ff};
         den_in = group_ff ? 64'(cnt_eff) * 64'd3 : 64'(cnt_eff);
         rem_in = '0;
         quo_in = '0;
      end
      if (cmd.div_step) begin
         num_in = {num_ff[63:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 64'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[63:0], 1'b1};
         end else begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[63:0], 1'b0};
         end
      end
      if (cmd.div2_load) begin
         if (status.temp_zero) begin
            zflag_in  = 1'b1;
            factor_in = ONE_Q16;
            ready_in  = 1'b1;
         end else begin
            zflag_in = 1'b0;
            num_in   = {9'd0, target_ff, 32'd0};
            den_in   = quo_ff[63:0];
            rem_in   = '0;
            quo_in   = '0;
         end
      end
      if (cmd.sqrt_load) begin
         sn_in  = quo_ff[55:0];
         res_in = '0;
         bit_in = 56'd1 << 54;
      end
      if (cmd.sqrt_step) begin
         bit_in = bit_ff >> 2;
         if ({1'b0, sn_ff} >= sq_trial) begin
            sn_in  = 56'({1'b0, sn_ff} - sq_trial);
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         if (cmd.sqrt_last) begin
            factor_in = res_in[31:0];
            ready_in  = 1'b1;
         end
      end

      if (cmd.mul) begin
         term_in = 55'((64'(item_ff.mass) * 64'(vv_ff)) >> 9);
         px_in   = $signed(item_ff.vel_x) * $signed({1'b0, factor_ff});
         py_in   = $signed(item_ff.vel_y) * $signed({1'b0, factor_ff});
      end

      if (cmd.resp_load) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_index    = item_ff.particle_index;
         rsp_in.vel_sq       = vv_ff;
         if (item_ff.opcode == OP_SCALE) begin
            rsp_in.scaled_vel_x = sx;
            rsp_in.scaled_vel_y = sy;
            rsp_in.factor_error = zflag_ff;
         end else begin
            rsp_in.scaled_vel_x = item_ff.vel_x;
            rsp_in.scaled_vel_y = item_ff.vel_y;
            rsp_in.factor_error = 1'b0;
            ready_in  = 1'b0;
            energy_in = energy_sum[64] ? '1 : energy_sum[63:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= TARGET_RST;
         count_ff     <= COUNT_BITS'(1);
         group_ff     <= 1'b0;
         energy_ff    <= '0;
         factor_ff    <= ONE_Q16;
         ready_ff     <= 1'b0;
         zflag_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         count_ff     <= count_in;
         group_ff     <= group_in;
         energy_ff    <= energy_in;
         factor_ff    <= factor_in;
         ready_ff     <= ready_in;
         zflag_ff     <= zflag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      vv_ff   <= vv_in;
      term_ff <= term_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      sn_ff   <= sn_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      rsp_ff  <= rsp_in;
   end

   a_scale_has_factor: assert property (@(posedge clock) disable iff (reset)
      (cmd.resp_load && item_ff.opcode == OP_SCALE) |-> ready_ff)
      else $error("scale response without factor");
   a_acc_opens_pass: assert property (@(posedge clock) disable iff (reset)
      (cmd.resp_load && item_ff.opcode == OP_ACCUMULATE) |=> !ready_ff)
      else $error("accumulate left factor marked ready");
   a_zero_unity: assert property (@(posedge clock) disable iff (reset)
      zflag_ff |-> (factor_ff == ONE_Q16))
      else $error("zero temperature with factor other than one");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten");

endmodule

// File: src/velocity_rescale_thermostat_top.sv
// velocity rescale thermostat: accumulate requests, and scale requests with the factor
// known, pass capture, square, sum, multiply and response load, which waits on a held
// response; the first scale request of a pass adds two 65-step divides and a 28-step
// root, skipping the second divide when the temperature comes out zero
// requests go one at a time through the controller's single-item sequence
// synchronous active-high reset restores register defaults, clears the energy sum,
// sets the factor to one and drops any pending response
`timescale 1ns / 1ps

module velocity_rescale_thermostat_top import vrt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   // register write channel, always ready
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // register writes are taken at once, no back-pressure needed
   assign csr_ready = 1'b1;

   // sequencer: one request at a time, iterates divider and root when needed
   vrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, state and the response register
   vrt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
